@@ hdl/vhd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vhd_pkg: shared types and constants for the vector heading block
// Polynomial coefficients (unsigned Q.24) and the octant side-band record.
// ----------------------------------------------------------------------------
package vhd_pkg;

    localparam int COEF_FRAC = 24;
    localparam int COEF_W    = 30;

    localparam logic [COEF_W-1:0] COEF_A = 30'd44695510;
    localparam logic [COEF_W-1:0] COEF_B = 30'd153142931;
    localparam logic [COEF_W-1:0] COEF_C = 30'd314931161;
    localparam logic [COEF_W-1:0] COEF_D = 30'd961263677;

    localparam int COORD_W   = 32;
    localparam int HEADING_W = 25;
    localparam int THRESH_W  = 16;

    // octant and special-case flags that ride along with each item
    typedef struct packed {
        logic too_small;
        logic swap;
        logic zpos;
        logic xpos;
    } t_side;

endpackage

@@ hdl/vhd_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vhd_div: pipelined restoring divider
// Forms floor(smaller * 2^RATIO_FRAC_BITS / larger), one quotient bit a stage.
// ----------------------------------------------------------------------------
module vhd_div #(
    parameter int RATIO_FRAC_BITS = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [31:0]                 i_smaller,
    input  logic [31:0]                 i_larger,
    input  vhd_pkg::t_side              i_side,
    output logic                        o_valid,
    output logic [RATIO_FRAC_BITS:0]    o_quot,
    output vhd_pkg::t_side              o_side
);
    import vhd_pkg::*;

    localparam int RF = RATIO_FRAC_BITS;
    localparam int QW = RF + 1;

    logic [31:0]   r_rem  [0:RF];
    logic [31:0]   r_den  [0:RF];
    logic [QW-1:0] r_q    [0:RF];
    t_side         r_side [0:RF];
    logic [RF:0]   r_vld;

    // top quotient bit is set only when both magnitudes are equal
    logic w_eq;
    assign w_eq = (i_smaller == i_larger);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
        if (i_en) begin
            r_rem[0]  <= w_eq ? 32'd0 : i_smaller;
            r_den[0]  <= i_larger;
            r_q[0]    <= QW'(w_eq);
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 1; k <= RF; k++) begin : g_step
        logic [32:0] w_sh;
        logic        w_ge;
        logic [32:0] w_diff;
        assign w_sh   = {r_rem[k-1], 1'b0};
        assign w_ge   = (w_sh >= {1'b0, r_den[k-1]});
        assign w_diff = w_sh - {1'b0, r_den[k-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
            if (i_en) begin
                r_rem[k]  <= w_ge ? w_diff[31:0] : w_sh[31:0];
                r_den[k]  <= r_den[k-1];
                r_q[k]    <= {r_q[k-1][QW-2:0], w_ge};
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_vld[RF];
    assign o_quot  = r_q[RF];
    assign o_side  = r_side[RF];

endmodule

@@ hdl/vhd_poly.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vhd_poly: polynomial arctangent and octant fold
// Horner evaluation with a register after each multiply, then the folds.
// ----------------------------------------------------------------------------
module vhd_poly #(
    parameter int ANGLE_FRAC_BITS = 16,
    parameter int RATIO_FRAC_BITS = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [RATIO_FRAC_BITS:0]    i_ratio,
    input  vhd_pkg::t_side              i_side,
    output logic                        o_valid,
    output logic [vhd_pkg::HEADING_W-1:0] o_heading,
    output logic                        o_too_small
);
    import vhd_pkg::*;

    localparam int RF  = RATIO_FRAC_BITS;
    localparam int RW  = RF + 1;
    localparam int UW  = COEF_W;
    localparam int PW  = UW + RW;
    localparam int AW  = ANGLE_FRAC_BITS + 10;
    localparam int SH  = RF + COEF_FRAC - ANGLE_FRAC_BITS;
    localparam int NS  = 11;

    localparam logic [PW:0]   HALF   = (PW+1)'(1) << (SH - 1);
    localparam logic [AW-1:0] DEG90  = AW'(90)  << ANGLE_FRAC_BITS;
    localparam logic [AW-1:0] DEG180 = AW'(180) << ANGLE_FRAC_BITS;
    localparam logic [AW-1:0] DEG360 = AW'(360) << ANGLE_FRAC_BITS;

    logic [NS-1:0] r_vld;
    t_side         r_side [0:NS-1];

    logic [2*RW-1:0] r_rr;
    logic [RW-1:0]   r_r1, r_r2, r_r3, r_r4, r_r5, r_r6, r_r7;
    logic [RW-1:0]   r_s2, r_s3, r_s4, r_s5;
    logic [PW-1:0]   r_pa, r_p1, r_p2, r_p3;
    logic [UW-1:0]   r_u1, r_u2, r_u3;
    logic [AW-1:0]   r_oct, r_half_fold;
    logic [HEADING_W-1:0] r_heading;

    logic [RW-1:0]   w_s;
    logic [PW:0]     w_rnd;
    logic [AW-1:0]   w_a, w_b, w_c;

    assign w_s   = RW'(r_rr >> RF);
    assign w_rnd = {1'b0, r_p3} + HALF;

    always_comb begin
        w_a = r_side[8].swap ? DEG90 - r_oct : r_oct;
        w_b = r_side[8].zpos ? DEG180 - w_a : w_a;
    end

    always_comb begin
        w_c = r_side[9].xpos ? DEG360 - r_half_fold : r_half_fold;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 1; k < NS; k++) begin
                r_side[k] <= r_side[k-1];
            end
            // square of the ratio
            r_rr <= (2*RW)'(i_ratio) * (2*RW)'(i_ratio);
            r_r1 <= i_ratio;
            // A * s
            r_pa <= PW'(COEF_A) * PW'(w_s);
            r_s2 <= w_s;
            r_r2 <= r_r1;
            r_u1 <= COEF_B - UW'(r_pa >> RF);
            r_s3 <= r_s2;
            r_r3 <= r_r2;
            r_p1 <= PW'(r_u1) * PW'(r_s3);
            r_s4 <= r_s3;
            r_r4 <= r_r3;
            r_u2 <= COEF_C - UW'(r_p1 >> RF);
            r_s5 <= r_s4;
            r_r5 <= r_r4;
            r_p2 <= PW'(r_u2) * PW'(r_s5);
            r_r6 <= r_r5;
            r_u3 <= COEF_D - UW'(r_p2 >> RF);
            r_r7 <= r_r6;
            r_p3 <= PW'(r_u3) * PW'(r_r7);
            r_oct <= AW'(w_rnd >> SH);
            r_half_fold <= w_b;
            // x fold, wrap of a full turn, zero for a vector below threshold
            if (r_side[9].too_small) begin
                r_heading <= '0;
            end else if (w_c >= DEG360) begin
                r_heading <= HEADING_W'(w_c - DEG360);
            end else begin
                r_heading <= HEADING_W'(w_c);
            end
        end
    end

    assign o_valid     = r_vld[NS-1];
    assign o_heading   = r_heading;
    assign o_too_small = r_side[NS-1].too_small;

endmodule

@@ hdl/vector_heading_degrees.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_heading_degrees: heading of a 2-D direction in degrees
// Magnitude and compare front end, pipelined divider, polynomial and fold.
// ----------------------------------------------------------------------------
// One vector is taken per clock while no finished heading waits, and each
// heading passes through an input register, the restoring divider, which
// resolves one quotient bit per stage, and then the eleven stages of the
// Horner multiplies and the octant fold. The whole pipeline holds when a
// finished heading is not taken, so o_ready follows the output side.
// ----------------------------------------------------------------------------
module vector_heading_degrees #(
    parameter int ANGLE_FRAC_BITS = 16,
    parameter int RATIO_FRAC_BITS = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [vhd_pkg::THRESH_W-1:0]    i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [vhd_pkg::COORD_W-1:0] i_x_coord,
    input  logic signed [vhd_pkg::COORD_W-1:0] i_z_coord,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [vhd_pkg::HEADING_W-1:0]   o_heading,
    output logic                            o_too_small
);
    import vhd_pkg::*;

    logic [THRESH_W-1:0] r_thr;
    logic                w_en;
    logic [31:0]         w_ax, w_az, w_larger, w_smaller;
    logic                w_swap;
    t_side               w_side;
    logic                r_vld;
    logic [31:0]         r_smaller, r_larger;
    t_side               r_side;
    logic                w_dvld;
    logic [RATIO_FRAC_BITS:0] w_quot;
    t_side               w_dside;

    // advance everything unless a finished heading waits
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THRESH_W'(1);
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_data;
        end
    end

    always_comb begin
        w_ax      = i_x_coord[31] ? 32'(-i_x_coord) : 32'(i_x_coord);
        w_az      = i_z_coord[31] ? 32'(-i_z_coord) : 32'(i_z_coord);
        w_swap    = (w_ax > w_az);
        w_larger  = w_swap ? w_ax : w_az;
        w_smaller = w_swap ? w_az : w_ax;
        w_side.too_small = (w_larger < {16'd0, r_thr}) || (w_larger == 32'd0);
        w_side.swap      = w_swap;
        w_side.zpos      = !i_z_coord[31] && (i_z_coord != 0);
        w_side.xpos      = !i_x_coord[31] && (i_x_coord != 0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_en) begin
            r_vld <= i_valid;
        end
        if (w_en) begin
            r_smaller <= w_smaller;
            r_larger  <= w_larger;
            r_side    <= w_side;
        end
    end

    vhd_div #(
        .RATIO_FRAC_BITS(RATIO_FRAC_BITS)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (r_vld),
        .i_smaller (r_smaller),
        .i_larger  (r_larger),
        .i_side    (r_side),
        .o_valid   (w_dvld),
        .o_quot    (w_quot),
        .o_side    (w_dside)
    );

    vhd_poly #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
        .RATIO_FRAC_BITS(RATIO_FRAC_BITS)
    ) u_poly (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (w_dvld),
        .i_ratio     (w_quot),
        .i_side      (w_dside),
        .o_valid     (o_valid),
        .o_heading   (o_heading),
        .o_too_small (o_too_small)
    );

endmodule

@@ hdl/vhd_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vhd_check: port-level checks for the vector heading block
// Bound to the top level; watches the handshakes and result fields.
// ----------------------------------------------------------------------------
module vhd_check (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [vhd_pkg::HEADING_W-1:0] o_heading,
    input logic                          o_too_small
);
    import vhd_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_small_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_too_small |-> o_heading == '0)
        else $error("too_small result with nonzero heading");

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("input taken while output stalled");

    a_result_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_heading) && $stable(o_too_small))
        else $error("stalled result changed");

endmodule

bind vector_heading_degrees vhd_check u_vhd_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_heading   (o_heading),
    .o_too_small (o_too_small)
);

@@ verif/vector_heading_degrees_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_heading_degrees_checker: heading predictor and result scoreboard
// Watches both channels of the heading block, works out the expected heading
// for each vector taken and compares it with each heading that leaves.
// ----------------------------------------------------------------------------
module vector_heading_degrees_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [vhd_pkg::THRESH_W-1:0]           i_cfg_data,
    input  logic                                   i_in_valid,
    input  logic                                   i_in_ready,
    input  logic signed [vhd_pkg::COORD_W-1:0]     i_x_coord,
    input  logic signed [vhd_pkg::COORD_W-1:0]     i_z_coord,
    input  logic                                   i_out_valid,
    input  logic                                   i_out_ready,
    input  logic [vhd_pkg::HEADING_W-1:0]          i_heading,
    input  logic                                   i_too_small,
    output int                                     o_fail_count,
    output int                                     o_pending
);
    import vhd_pkg::*;

    localparam int ANGLE_FRAC = 16;
    localparam int RATIO_FRAC = 24;

    typedef struct {
        logic [HEADING_W-1:0] heading;
        logic                 too_small;
    } t_heading;

    t_heading           expected_headings[$];
    logic [THRESH_W-1:0] threshold;

    function automatic logic [63:0] abs_coord(input logic [31:0] v);
        abs_coord = v[31] ? {32'd0, (~v) + 32'd1} : {32'd0, v};
        if (v == 32'h8000_0000) abs_coord = 64'h8000_0000;
    endfunction

    function automatic t_heading predict_heading(input logic [31:0] xc, input logic [31:0] zc);
        logic [63:0] ax, az, big, lit, r, s, u1, u2, u3, ang, one;
        t_heading res;
        ax = abs_coord(xc);
        az = abs_coord(zc);
        big = (ax > az) ? ax : az;
        lit = (ax > az) ? az : ax;
        one = 64'd1 << ANGLE_FRAC;
        if (big < {48'd0, threshold} || big == 0) begin
            res.heading = '0;
            res.too_small = 1'b1;
            return res;
        end
        r  = (lit << RATIO_FRAC) / big;
        s  = (r * r) >> RATIO_FRAC;
        u1 = COEF_B - ((COEF_A * s) >> RATIO_FRAC);
        u2 = COEF_C - ((u1 * s) >> RATIO_FRAC);
        u3 = COEF_D - ((u2 * s) >> RATIO_FRAC);
        ang = (u3 * r + (64'd1 << (RATIO_FRAC + COEF_FRAC - ANGLE_FRAC - 1)))
              >> (RATIO_FRAC + COEF_FRAC - ANGLE_FRAC);
        if (ax > az) ang = 90 * one - ang;
        if (!zc[31] && zc != 0) ang = 180 * one - ang;
        if (!xc[31] && xc != 0) ang = 360 * one - ang;
        if (ang >= 360 * one) ang = ang - 360 * one;
        res.heading = ang[HEADING_W-1:0];
        res.too_small = 1'b0;
        return res;
    endfunction

    assign o_pending = expected_headings.size();

    always @(posedge i_clk) begin
        t_heading want;
        if (!i_rst_n) begin
            threshold <= 16'd1;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) threshold <= i_cfg_data;
            if (i_in_valid && i_in_ready)
                expected_headings.push_back(predict_heading(i_x_coord, i_z_coord));
            if (i_out_valid && i_out_ready) begin
                if (expected_headings.size() == 0) begin
                    $error("heading transfer with nothing expected");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_headings.pop_front();
                    if (want.heading !== i_heading) begin
                        $error("heading: expected %0d actual %0d", want.heading, i_heading);
                        o_fail_count <= o_fail_count + 1;
                    end else if (want.too_small !== i_too_small) begin
                        $error("too_small: expected %0d actual %0d",
                               want.too_small, i_too_small);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

@@ verif/vector_heading_degrees_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_heading_degrees_test: stimulus and verdict for the heading block
// Directed corner vectors, then random vectors under several thresholds,
// with random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
module vector_heading_degrees_test;
    import vhd_pkg::*;

    logic                      clk = 0;
    logic                      rst_n = 0;
    logic                      cfg_we = 0;
    logic [THRESH_W-1:0]       cfg_data = '0;
    logic                      in_valid = 0;
    logic                      in_ready;
    logic signed [COORD_W-1:0] x_coord = '0;
    logic signed [COORD_W-1:0] z_coord = '0;
    logic                      out_valid;
    logic                      out_ready = 0;
    logic [HEADING_W-1:0]      heading;
    logic                      too_small;
    int                        fail_count;
    int                        pending;
    bit                        hold_output = 0;
    bit                        stim_done = 0;

    always #5 clk = ~clk;

    vector_heading_degrees dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_ready(in_ready), .i_x_coord(x_coord),
        .i_z_coord(z_coord), .o_valid(out_valid), .i_ready(out_ready),
        .o_heading(heading), .o_too_small(too_small)
    );

    vector_heading_degrees_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_x_coord(x_coord),
        .i_z_coord(z_coord), .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_heading(heading), .i_too_small(too_small), .o_fail_count(fail_count),
        .o_pending(pending)
    );

    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 1) == 0) return 0;
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [31:0] random_coord();
        case ($urandom_range(0, 5))
            0: random_coord = $urandom_range(0, 200) - 100;
            1: random_coord = $urandom() >> $urandom_range(0, 31);
            2: random_coord = -($urandom() >> $urandom_range(0, 31));
            3: random_coord = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: random_coord = $urandom();
        endcase
    endfunction

    // hold the valid high until the transfer, then idle for the given gap
    task automatic send_vector(input logic [31:0] xc, input logic [31:0] zc,
                               input int gap);
        in_valid <= 1'b1;
        x_coord  <= xc;
        z_coord  <= zc;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic settle_and_write(input logic [THRESH_W-1:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // receiver: random stalls, overridden by the long hold-off
    always @(posedge clk) begin
        if (hold_output || !rst_n) out_ready <= 1'b0;
        else out_ready <= ($urandom_range(0, 9) < 7);
    end

    initial begin
        logic [THRESH_W-1:0] levels[5];
        levels = '{16'd0, 16'd1, 16'hFFFF, 16'd256, 16'd0};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners at the reset threshold
        send_vector(32'd0, 32'd0, 0);
        send_vector(32'h8000_0000, 32'h8000_0000, 0);
        send_vector(32'h7FFF_FFFF, 32'h8000_0000, 0);
        send_vector(32'h8000_0000, 32'h7FFF_FFFF, 1);
        send_vector(32'd0, -32'sd65536, 0);
        send_vector(32'd0, 32'd65536, 0);
        send_vector(32'd65536, 32'd0, 0);
        send_vector(-32'sd65536, 32'd0, 2);
        send_vector(32'd65536, 32'd65536, 0);
        send_vector(-32'sd65536, -32'sd65536, 0);
        send_vector(32'd1, -32'sd1, 0);
        send_vector(-32'sd1, 32'd1, 0);
        send_vector(32'd1, -32'sd100000, 0);
        send_vector(-32'sd1, -32'sd100000, 0);
        send_vector(32'hFFFF_FFFF, 32'h7FFF_FFFF, 0);
        send_vector(32'h5555_5555, 32'hAAAA_AAAA, 0);
        send_vector(32'hAAAA_AAAA, 32'h5555_5555, 0);

        // long output stall while vectors keep coming
        fork
            begin
                hold_output <= 1'b1;
                repeat (120) @(posedge clk);
                hold_output <= 1'b0;
            end
            for (int i = 0; i < 60; i++) send_vector(random_coord(), random_coord(), 0);
        join

        for (int phase = 0; phase < 5; phase++) begin
            settle_and_write(levels[phase]);
            for (int i = 0; i < 75; i++) begin
                if (i == 0 && phase == 0) send_vector(32'd0, 32'd0, 0);
                else if (i < 4) send_vector($urandom_range(0, 70000) - 35000,
                                            $urandom_range(0, 70000) - 35000, gap_length());
                else send_vector(random_coord(), random_coord(), gap_length());
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (fail_count == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
